FILE: sv/hfvc_pkg.sv
// Shared types and constants of the height-field voxel clip core.
// No dependencies; imported by every module of the block.
package hfvc_pkg;

   // Height store geometry
   localparam int STORE_AW = 16;
   localparam int STORE_DW = 32;

   // 1.0 in Q1.14 weights
   localparam logic signed [15:0] WEIGHT_ONE = 16'sd16384;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_CLIP_MODE     = 3'd0,
      CSR_CLIP_CONSTANT = 3'd1,
      CSR_MULT_FACTOR   = 3'd2,
      CSR_PLANE_ADD     = 3'd3,
      CSR_X_ORIGIN      = 3'd4,
      CSR_Y_ORIGIN      = 3'd5,
      CSR_X_SCALE       = 3'd6,
      CSR_Y_SCALE       = 3'd7
   } csr_index_type;

   // Replacement of a clipped voxel
   typedef enum logic [1:0] {
      MODE_CONST = 2'd0,
      MODE_MULT  = 2'd1,
      MODE_PLANE = 2'd2,
      MODE_KEEP  = 2'd3
   } clip_mode_type;

   // Word opcode
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_VOXEL = 1'b1;

   // Payload that rides along the pipeline
   typedef struct packed {
      logic                op;
      logic [15:0]         addr;
      logic [31:0]         height;
      logic signed [15:0]  voxel;
      logic signed [31:0]  pz;
      logic                bypass;
      logic signed [15:0]  mul_sat;
      logic signed [15:0]  add_sat;
      logic                in_grid;
      logic signed [15:0]  w0x;
      logic signed [15:0]  w1x;
      logic signed [15:0]  w0y;
      logic signed [15:0]  w1y;
   } item_type;

endpackage

FILE: sv/hfvc_height_ram.sv
// One copy of the height store: one write port, one registered read port.
// Depends on hfvc_pkg for the store geometry.
module hfvc_height_ram
   import hfvc_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [STORE_AW-1:0] wr_addr,
   input  logic [STORE_DW-1:0] wr_data,
   input  logic                rd_en,
   input  logic [STORE_AW-1:0] rd_addr,
   output logic [STORE_DW-1:0] rd_data
);

   logic [STORE_DW-1:0] mem [0:(1<<STORE_AW)-1];
   logic [STORE_DW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, held while stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/height_field_voxel_clip_core.sv
// Height-field voxel clip core: top level with the full pipeline.
// Depends on hfvc_pkg and hfvc_height_ram (four copies of the height store).
//
// Usage: words enter on the req_ stream. req_tuser[0] = 0 is a load word that
// writes one height into the grid store and gives no response; 1 is a voxel
// word that gives one response word on the rsp_ stream (value in rsp_tdata,
// clipped flag in rsp_tuser[0]). Configuration is written on the csr_ port
// while no word is in flight.
// Throughput: one word per cycle unless rsp_ stalls. Each voxel needs four height
// reads per cycle; the store is kept in four identical copies, each with one read
// port. A voxel passes nine pipeline stages plus the output register before it is
// shown on rsp_; a stall holds it in place.
// Load words write the store at pipeline stage five, in order with voxel
// reads, so a voxel sees every load accepted before it.
// Reset clears all valid bits and sets the configuration registers to defaults;
// the store holds no defined content until written. When the receiver stalls,
// words pack up stage by stage; req_tready drops only when every stage is full.
module height_field_voxel_clip_core
   import hfvc_pkg::*;
#(
   parameter int GRID_COLS = 256,
   parameter int GRID_ROWS = 256
)
(
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: grid_addr[15:0], height_value[47:16], voxel_value[63:48],
   //        plane_x[95:64], plane_y[127:96], plane_z[159:128]
   input  logic [159:0] req_tdata,
   // tuser: opcode[0]
   input  logic [0:0]   req_tuser,
   // response stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: out_value[15:0]
   output logic [15:0]  rsp_tdata,
   // tuser: was_clipped[0]
   output logic [0:0]   rsp_tuser,
   // configuration writes
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wr_data
);

   localparam int NST = 9;
   localparam int CW  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int RW  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

   // configuration registers
   clip_mode_type      clip_mode_ff;
   logic signed [15:0] clip_constant_ff;
   logic signed [15:0] mult_factor_ff;
   logic signed [15:0] plane_add_ff;
   logic signed [31:0] x_origin_ff;
   logic signed [31:0] y_origin_ff;
   logic [31:0]        x_scale_ff;
   logic [31:0]        y_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_mode_ff     <= MODE_CONST;
         clip_constant_ff <= 16'sd0;
         mult_factor_ff   <= 16'sd2;
         plane_add_ff     <= 16'sd2;
         x_origin_ff      <= 32'sd0;
         y_origin_ff      <= 32'sd0;
         x_scale_ff       <= 32'd65536;
         y_scale_ff       <= 32'd65536;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_addr))
            CSR_CLIP_MODE:     clip_mode_ff     <= clip_mode_type'(csr_wr_data[1:0]);
            CSR_CLIP_CONSTANT: clip_constant_ff <= csr_wr_data[15:0];
            CSR_MULT_FACTOR:   mult_factor_ff   <= csr_wr_data[15:0];
            CSR_PLANE_ADD:     plane_add_ff     <= csr_wr_data[15:0];
            CSR_X_ORIGIN:      x_origin_ff      <= csr_wr_data;
            CSR_Y_ORIGIN:      y_origin_ff      <= csr_wr_data;
            CSR_X_SCALE:       x_scale_ff       <= csr_wr_data;
            CSR_Y_SCALE:       y_scale_ff       <= csr_wr_data;
         endcase
      end
   end

   // stage valids, payload and per-stage enables
   logic     vld_ff  [1:NST];
   item_type item_ff [1:NST];
   logic     en      [1:NST+1];
   logic     rsp_valid_ff;

   always_comb begin
      en[NST+1] = !rsp_valid_ff || rsp_tready;
      for (int k = NST; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NST; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         if (en[1]) begin
            vld_ff[1] <= req_tvalid;
         end
         for (int k = 2; k <= NST; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // ---- stage 1: offsets from origin, constant pass test
   item_type    item_in;
   logic [32:0] dx, dy;
   logic [32:0] mag_x_ff, mag_y_ff;
   logic        neg_x_ff, neg_y_ff;

   always_comb begin
      item_in        = '0;
      item_in.op     = req_tuser[0];
      item_in.addr   = req_tdata[15:0];
      item_in.height = req_tdata[47:16];
      item_in.voxel  = req_tdata[63:48];
      item_in.pz     = req_tdata[159:128];
      item_in.bypass = (clip_mode_ff == MODE_CONST) &&
                       (req_tdata[63:48] == clip_constant_ff);
      dx = {req_tdata[95], req_tdata[95:64]} - {x_origin_ff[31], x_origin_ff};
      dy = {req_tdata[127], req_tdata[127:96]} - {y_origin_ff[31], y_origin_ff};
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         item_ff[1] <= item_in;
         neg_x_ff   <= dx[32];
         neg_y_ff   <= dy[32];
         mag_x_ff   <= dx[32] ? (~dx + 33'd1) : dx;
         mag_y_ff   <= dy[32] ? (~dy + 33'd1) : dy;
      end
   end

   // ---- stage 2: partial products of offset times scale, replacement values
   logic [48:0]        pxh_ff, pxl_ff, pyh_ff, pyl_ff;
   logic               neg_x2_ff, neg_y2_ff;
   logic signed [31:0] vprod;
   logic signed [16:0] vsum;
   item_type           item2;

   always_comb begin
      item2 = item_ff[1];
      vprod = item_ff[1].voxel * mult_factor_ff;
      vsum  = 17'(item_ff[1].voxel) + 17'(plane_add_ff);
      if (vprod > 32'sd32767) begin
         item2.mul_sat = 16'sh7fff;
      end else if (vprod < -32'sd32768) begin
         item2.mul_sat = 16'sh8000;
      end else begin
         item2.mul_sat = vprod[15:0];
      end
      if (item_ff[1].voxel == 16'sd0) begin
         item2.add_sat = 16'sd0;
      end else if (vsum > 17'sd32767) begin
         item2.add_sat = 16'sh7fff;
      end else if (vsum < -17'sd32768) begin
         item2.add_sat = 16'sh8000;
      end else begin
         item2.add_sat = vsum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         item_ff[2] <= item2;
         neg_x2_ff  <= neg_x_ff;
         neg_y2_ff  <= neg_y_ff;
         pxh_ff     <= 49'(mag_x_ff) * 49'(x_scale_ff[31:16]);
         pxl_ff     <= 49'(mag_x_ff) * 49'(x_scale_ff[15:0]);
         pyh_ff     <= 49'(mag_y_ff) * 49'(y_scale_ff[31:16]);
         pyl_ff     <= 49'(mag_y_ff) * 49'(y_scale_ff[15:0]);
      end
   end

   // ---- stage 3: grid index, fraction, range test and weights
   logic [64:0]        px, py;
   logic               inx, iny;
   logic [CW-1:0]      x0, x1;
   logic [RW-1:0]      y0, y1;
   logic signed [15:0] fx, fy;
   logic [CW-1:0]      x0_ff, x1_ff;
   logic [RW-1:0]      y0_ff, y1_ff;
   item_type           item3;

   always_comb begin
      item3 = item_ff[2];
      px = {pxh_ff, 16'd0} + {16'd0, pxl_ff};
      py = {pyh_ff, 16'd0} + {16'd0, pyl_ff};
      // x axis
      if (neg_x2_ff) begin
         inx = (px[64:30] == 35'd0);
         x0  = '0;
         fx  = -$signed({2'b00, px[29:16]});
      end else begin
         inx = (px[64:30] < 35'(GRID_COLS));
         x0  = px[30+CW-1:30];
         fx  = $signed({2'b00, px[29:16]});
      end
      // y axis
      if (neg_y2_ff) begin
         iny = (py[64:30] == 35'd0);
         y0  = '0;
         fy  = -$signed({2'b00, py[29:16]});
      end else begin
         iny = (py[64:30] < 35'(GRID_ROWS));
         y0  = py[30+RW-1:30];
         fy  = $signed({2'b00, py[29:16]});
      end
      // last column or row: full weight on the edge sample
      if (32'(x0) == 32'(GRID_COLS - 1)) begin
         x1 = x0;
         item3.w0x = WEIGHT_ONE;
         item3.w1x = 16'sd0;
      end else begin
         x1 = x0 + CW'(1);
         item3.w0x = WEIGHT_ONE - fx;
         item3.w1x = fx;
      end
      if (32'(y0) == 32'(GRID_ROWS - 1)) begin
         y1 = y0;
         item3.w0y = WEIGHT_ONE;
         item3.w1y = 16'sd0;
      end else begin
         y1 = y0 + RW'(1);
         item3.w0y = WEIGHT_ONE - fy;
         item3.w1y = fy;
      end
      item3.in_grid = inx && iny;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         item_ff[3] <= item3;
         x0_ff <= x0;
         x1_ff <= x1;
         y0_ff <= y0;
         y1_ff <= y1;
      end
   end

   // ---- stage 4: store addresses of the four neighbors
   logic [31:0]         a00, a01, a10, a11;
   logic [STORE_AW-1:0] a00_ff, a01_ff, a10_ff, a11_ff;

   always_comb begin
      a00 = 32'(y0_ff) * 32'(GRID_COLS) + 32'(x0_ff);
      a01 = 32'(y0_ff) * 32'(GRID_COLS) + 32'(x1_ff);
      a10 = 32'(y1_ff) * 32'(GRID_COLS) + 32'(x0_ff);
      a11 = 32'(y1_ff) * 32'(GRID_COLS) + 32'(x1_ff);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         item_ff[4] <= item_ff[3];
         a00_ff <= a00[STORE_AW-1:0];
         a01_ff <= a01[STORE_AW-1:0];
         a10_ff <= a10[STORE_AW-1:0];
         a11_ff <= a11[STORE_AW-1:0];
      end
   end

   // ---- stage 5: store access; loads write all copies in word order
   logic                store_wr;
   logic [STORE_DW-1:0] h00, h01, h10, h11;

   assign store_wr = en[5] && vld_ff[4] && (item_ff[4].op == OP_LOAD);

   hfvc_height_ram u_ram00 (
      .clock(clock), .wr_en(store_wr), .wr_addr(item_ff[4].addr),
      .wr_data(item_ff[4].height), .rd_en(en[5]), .rd_addr(a00_ff), .rd_data(h00)
   );
   hfvc_height_ram u_ram01 (
      .clock(clock), .wr_en(store_wr), .wr_addr(item_ff[4].addr),
      .wr_data(item_ff[4].height), .rd_en(en[5]), .rd_addr(a01_ff), .rd_data(h01)
   );
   hfvc_height_ram u_ram10 (
      .clock(clock), .wr_en(store_wr), .wr_addr(item_ff[4].addr),
      .wr_data(item_ff[4].height), .rd_en(en[5]), .rd_addr(a10_ff), .rd_data(h10)
   );
   hfvc_height_ram u_ram11 (
      .clock(clock), .wr_en(store_wr), .wr_addr(item_ff[4].addr),
      .wr_data(item_ff[4].height), .rd_en(en[5]), .rd_addr(a11_ff), .rd_data(h11)
   );

   always_ff @(posedge clock) begin
      if (en[5]) begin
         item_ff[5] <= item_ff[4];
      end
   end

   // ---- stage 6: heights times x weights
   logic signed [47:0] p00_ff, p01_ff, p10_ff, p11_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         item_ff[6] <= item_ff[5];
         p00_ff <= $signed(h00) * item_ff[5].w0x;
         p01_ff <= $signed(h01) * item_ff[5].w1x;
         p10_ff <= $signed(h10) * item_ff[5].w0x;
         p11_ff <= $signed(h11) * item_ff[5].w1x;
      end
   end

   // ---- stage 7: row sums along x
   logic signed [48:0] r0_ff, r1_ff;

   always_ff @(posedge clock) begin
      if (en[7]) begin
         item_ff[7] <= item_ff[6];
         r0_ff <= 49'(p00_ff) + 49'(p01_ff);
         r1_ff <= 49'(p10_ff) + 49'(p11_ff);
      end
   end

   // ---- stage 8: row sums times y weights
   logic signed [64:0] q0_ff, q1_ff;

   always_ff @(posedge clock) begin
      if (en[8]) begin
         item_ff[8] <= item_ff[7];
         q0_ff <= r0_ff * item_ff[7].w0y;
         q1_ff <= r1_ff * item_ff[7].w1y;
      end
   end

   // ---- stage 9: final height against z (28 fraction bits)
   logic signed [65:0] q;
   logic signed [65:0] z;
   logic               clip_ff;

   always_comb begin
      q = 66'(q0_ff) + 66'(q1_ff);
      z = {{6{item_ff[8].pz[31]}}, item_ff[8].pz, 28'd0};
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         item_ff[9] <= item_ff[8];
         clip_ff    <= !item_ff[8].bypass && (!item_ff[8].in_grid || (q < z));
      end
   end

   // ---- output register: replacement of clipped voxels
   logic signed [15:0] res;
   logic [15:0]        rsp_data_ff;
   logic               rsp_clip_ff;

   always_comb begin
      res = item_ff[9].voxel;
      if (clip_ff) begin
         case (clip_mode_ff)
            MODE_CONST: res = clip_constant_ff;
            MODE_MULT:  res = item_ff[9].mul_sat;
            MODE_PLANE: res = item_ff[9].add_sat;
            default:    res = item_ff[9].voxel;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en[NST+1]) begin
         rsp_valid_ff <= vld_ff[NST] && (item_ff[NST].op == OP_VOXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (en[NST+1]) begin
         rsp_data_ff <= res;
         rsp_clip_ff <= clip_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_clip_ff;

`ifndef SYNTHESIS
   // an empty first stage always takes a word
   assert property (@(posedge clock) disable iff (reset) !vld_ff[1] |-> req_tready)
      else $error("req_tready low with empty first stage");

   // a point outside the grid is clipped unless constant pass applies
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[NST] && !item_ff[NST].in_grid && !item_ff[NST].bypass |-> clip_ff)
      else $error("outside point not clipped");

   // a pending response only leaves when taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("response lost while stalled");
`endif

endmodule

FILE: dv/height_field_voxel_clip_core_tb.sv
// Self-checking bench for height_field_voxel_clip_core: a directed table of
// words, then random load/voxel traffic checked against an in-bench predictor.
// Depends on hfvc_pkg and the core RTL only.
module height_field_voxel_clip_core_tb;
   import hfvc_pkg::*;

   localparam int COLS = 256;
   localparam int ROWS = 256;
   localparam int WIN  = 12;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 30;

   typedef struct {
      logic        op;
      logic [15:0] addr;
      logic [31:0] height;
      logic [15:0] voxel;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic        known;      // expected value typed into the table
      logic [15:0] exp_value;
      logic        exp_clip;
   } word_row_type;

   typedef struct {
      logic [15:0] value;
      logic        clip;
   } voxel_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [159:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [15:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_wr_en;
   logic [2:0]   csr_addr;
   logic [31:0]  csr_wr_data;

   // predictor state
   logic signed [31:0] heights [0:65535];
   bit                 height_written [0:65535];
   logic [1:0]         m_mode;
   logic signed [15:0] m_const, m_factor, m_add;
   logic signed [31:0] m_xorg, m_yorg;
   logic [31:0]        m_xscale, m_yscale;

   voxel_result_type expected_results[$];
   int  error_count;
   int  mismatch_count;
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  recv_hold;
   int  idle_cycles;

   height_field_voxel_clip_core #(.GRID_COLS(COLS), .GRID_ROWS(ROWS)) uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Map one axis; false when the point falls outside the grid
   function automatic bit map_axis(input logic signed [31:0] coord,
                                   input logic signed [31:0] origin,
                                   input logic [31:0] scale, input int n,
                                   output int idx, output longint frac);
      longint          d;
      longint unsigned mag, p, ip;
      longint          f;
      d = longint'(coord) - longint'(origin);
      mag = (d < 0) ? longint'(-d) : d;
      p = mag * longint'({32'd0, scale});
      ip = p >> 30;
      f = longint'((p & 64'h3FFF_FFFF) >> 16);
      if (d < 0) begin
         if (ip != 0) return 0;
         idx = 0;
         frac = -f;
      end else begin
         if (ip >= n) return 0;
         idx = int'(ip);
         frac = f;
      end
      return 1;
   endfunction

   function automatic int grid_index(input int row, input int col);
      return (row * COLS + col) & 16'hFFFF;
   endfunction

   function automatic longint stored_height(input int row, input int col);
      return longint'(heights[grid_index(row, col)]);
   endfunction

   function automatic longint sat16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // True when a word reads only heights that have been loaded
   function automatic bit reads_defined(input word_row_type w);
      int     x0, y0, x1, y1;
      longint fx, fy;
      if (w.op == OP_LOAD) return 1;
      if (m_mode == MODE_CONST && $signed(w.voxel) == m_const) return 1;
      if (!map_axis(w.px, m_xorg, m_xscale, COLS, x0, fx) ||
          !map_axis(w.py, m_yorg, m_yscale, ROWS, y0, fy))
         return 1;
      x1 = (x0 + 1 >= COLS) ? x0 : x0 + 1;
      y1 = (y0 + 1 >= ROWS) ? y0 : y0 + 1;
      return height_written[grid_index(y0, x0)] && height_written[grid_index(y0, x1)] &&
             height_written[grid_index(y1, x0)] && height_written[grid_index(y1, x1)];
   endfunction

   // Clip decision and replacement value for one voxel word
   function automatic voxel_result_type clip_voxel(input word_row_type w);
      voxel_result_type r;
      int     x0, y0, x1, y1;
      longint fx, fy, w0x, w1x, w0y, w1y, r0, r1, q, z, v, res;
      bit     clip;
      v = longint'($signed(w.voxel));
      if (m_mode == MODE_CONST && v == longint'(m_const)) begin
         r.value = w.voxel;
         r.clip = 1'b0;
         return r;
      end
      if (!map_axis(w.px, m_xorg, m_xscale, COLS, x0, fx) ||
          !map_axis(w.py, m_yorg, m_yscale, ROWS, y0, fy)) begin
         clip = 1;
      end else begin
         if (x0 + 1 >= COLS) begin
            x1 = x0; w0x = 16384; w1x = 0;
         end else begin
            x1 = x0 + 1; w1x = fx; w0x = 16384 - fx;
         end
         if (y0 + 1 >= ROWS) begin
            y1 = y0; w0y = 16384; w1y = 0;
         end else begin
            y1 = y0 + 1; w1y = fy; w0y = 16384 - fy;
         end
         r0 = stored_height(y0, x0) * w0x + stored_height(y0, x1) * w1x;
         r1 = stored_height(y1, x0) * w0x + stored_height(y1, x1) * w1x;
         q = r0 * w0y + r1 * w1y;
         z = longint'($signed(w.pz)) * (64'sd1 <<< 28);
         clip = q < z;
      end
      if (!clip) res = v;
      else case (m_mode)
         MODE_CONST: res = longint'(m_const);
         MODE_MULT:  res = sat16(v * longint'(m_factor));
         MODE_PLANE: res = (v != 0) ? sat16(v + longint'(m_add)) : v;
         default:    res = v;
      endcase
      r.value = res[15:0];
      r.clip = clip;
      return r;
   endfunction

   // Voxel word checked against typed-in results where given, else the predictor
   task automatic check_result(input logic [15:0] got_value, input logic got_clip);
      voxel_result_type e;
      if (expected_results.size() == 0) begin
         error_count++;
         if (mismatch_count++ < 10)
            $display("unexpected response word value=%0d clip=%0b",
                     $signed(got_value), got_clip);
         return;
      end
      e = expected_results.pop_front();
      if (e.value !== got_value || e.clip !== got_clip) begin
         error_count++;
         if (mismatch_count++ < 10)
            $display("mismatch: expected value=%0d clip=%0b, got value=%0d clip=%0b",
                     $signed(e.value), e.clip, $signed(got_value), got_clip);
      end
   endtask

   // Receiver: random stalls, long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata, rsp_tuser[0]);
         rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_addr <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_CLIP_MODE:     m_mode = data[1:0];
         CSR_CLIP_CONSTANT: m_const = data[15:0];
         CSR_MULT_FACTOR:   m_factor = data[15:0];
         CSR_PLANE_ADD:     m_add = data[15:0];
         CSR_X_ORIGIN:      m_xorg = data;
         CSR_Y_ORIGIN:      m_yorg = data;
         CSR_X_SCALE:       m_xscale = data;
         CSR_Y_SCALE:       m_yscale = data;
         default: ;
      endcase
   endtask

   // Send one word; valid held across back-to-back words
   task automatic send_word(input word_row_type w);
      voxel_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= w.op;
      req_tdata <= {w.pz, w.py, w.px, w.voxel, w.height, w.addr};
      do @(posedge clock); while (!req_tready);
      if (w.op == OP_LOAD) begin
         heights[w.addr] = w.height;
         height_written[w.addr] = 1;
      end else begin
         r = clip_voxel(w);
         if (w.known) begin
            r.value = w.exp_value;
            r.clip = w.exp_clip;
         end
         expected_results.push_back(r);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic word_row_type load_word(input logic [15:0] a, input logic [31:0] h);
      word_row_type w;
      w = '{default: '0};
      w.op = OP_LOAD;
      w.addr = a;
      w.height = h;
      return w;
   endfunction

   function automatic word_row_type voxel_word(input logic [15:0] v, input logic [31:0] x,
                                            input logic [31:0] y, input logic [31:0] z);
      word_row_type w;
      w = '{default: '0};
      w.op = OP_VOXEL;
      w.voxel = v; w.px = x; w.py = y; w.pz = z;
      w.addr = 16'($urandom); w.height = $urandom;
      return w;
   endfunction

   // Random word; in-range points land mostly in the loaded corner window
   function automatic word_row_type random_word();
      word_row_type w;
      logic [31:0] x, y, z;
      if ($urandom_range(99) < 20)
         return load_word(16'($urandom), $urandom);
      case ($urandom_range(3))
         0: begin x = $urandom; y = $urandom; z = $urandom; end
         default: begin
            // points near the grid corner: raw plane units
            x = m_xorg + $signed(32'($urandom_range(0, 9 << 14))) - (2 << 14);
            y = m_yorg + $signed(32'($urandom_range(0, 9 << 14))) - (2 << 14);
            z = $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
         end
      endcase
      w = voxel_word(16'($urandom), x, y, z);
      if ($urandom_range(9) == 0) w.voxel = m_const;
      if ($urandom_range(9) == 0) w.voxel = 16'h0000;
      return w;
   endfunction

   task automatic random_phase(input int count);
      word_row_type w;
      for (int i = 0; i < count; i++) begin
         do w = random_word(); while (!reads_defined(w));
         send_word(w);
      end
   endtask

   word_row_type directed[$];

   initial begin
      word_row_type w;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_wr_en = 1'b0;
      csr_addr = '0;
      csr_wr_data = '0;
      recv_hold = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      error_count = 0;
      mismatch_count = 0;
      m_mode = MODE_CONST; m_const = 0; m_factor = 2; m_add = 2;
      m_xorg = 0; m_yorg = 0; m_xscale = 32'h0001_0000; m_yscale = 32'h0001_0000;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table (reset config: const mode, constant 0, unit scale)
      directed.push_back(load_word(16'h0000, 32'h0000_4000));
      directed.push_back(load_word(16'h0001, 32'h7FFF_FFFF));
      directed.push_back(load_word(16'h0100, 32'h8000_0000));
      directed.push_back(load_word(16'h0101, 32'h0000_0000));
      directed.push_back(load_word(16'hFFFF, 32'hFFFF_C000));
      // constant pass: voxel equals constant, never clipped
      w = voxel_word(16'h0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      w.known = 1; w.exp_value = 16'h0000; w.exp_clip = 0; directed.push_back(w);
      // far outside the grid in either direction: clipped to constant 0
      w = voxel_word(16'h7FFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
      w.known = 1; w.exp_value = 16'h0000; w.exp_clip = 1; directed.push_back(w);
      w = voxel_word(16'h8000, 32'h0, 32'hFFFF_0000, 32'h0);
      w.known = 1; w.exp_value = 16'h0000; w.exp_clip = 1; directed.push_back(w);
      // on sample (0,0), height 1.0: z below keeps, z above clips
      w = voxel_word(16'h0005, 32'h0, 32'h0, 32'h0000_2000);
      w.known = 1; w.exp_value = 16'h0005; w.exp_clip = 0; directed.push_back(w);
      w = voxel_word(16'h0005, 32'h0, 32'h0, 32'h0000_4001);
      w.known = 1; w.exp_value = 16'h0000; w.exp_clip = 1; directed.push_back(w);
      // interpolated and negative-fraction points
      directed.push_back(voxel_word(16'h1234, 32'h0000_2000, 32'h0000_2000, 32'h0));
      directed.push_back(voxel_word(16'h1234, 32'hFFFF_E000, 32'h0000_1000, 32'h0));
      directed.push_back(voxel_word(16'h0001, 32'h0000_2000, 32'hFFFF_F000, 32'h8000_0000));
      // last row and column corner
      directed.push_back(voxel_word(16'h0042, 32'h003F_E000, 32'h003F_F000,
                                    32'hFFFF_C000));
      directed.push_back(voxel_word(16'h0042, 32'h003F_E000, 32'h003F_F000,
                                    32'hFFFF_C001));
      foreach (directed[i]) send_word(directed[i]);
      wait_idle();

      // Fill the corner window; random points reading elsewhere are redrawn
      for (int r = 0; r < WIN; r++)
         for (int c = 0; c < WIN; c++)
            send_word(load_word(16'(r * COLS + c),
                                $signed(32'($urandom_range(0, 1 << 19))) - (1 << 18)));
      wait_idle();

      // Multiply mode with saturating factor, zero scale on x
      write_csr(CSR_CLIP_MODE, 32'(MODE_MULT));
      write_csr(CSR_MULT_FACTOR, 32'h0000_7FFF);
      write_csr(CSR_X_SCALE, 32'h0);
      send_word(voxel_word(16'h7FFF, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF));
      send_word(voxel_word(16'h8000, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF));
      send_word(voxel_word(16'h0003, 32'h1234_5678, 32'h0, 32'h8000_0000));
      wait_idle();

      // Phase 1: sender idles a little, receiver a lot
      send_idle_pct = 11; recv_idle_pct = 75;
      write_csr(CSR_MULT_FACTOR, 32'h0000_8000);
      write_csr(CSR_X_SCALE, 32'h0001_8000);
      write_csr(CSR_Y_SCALE, 32'h0000_C000);
      write_csr(CSR_X_ORIGIN, 32'hFFFF_0000);
      write_csr(CSR_Y_ORIGIN, 32'h0000_8000);
      random_phase(400);
      wait_idle();

      // Phase 2: plane mode, saturating adds; long receiver hold mid-phase
      send_idle_pct = 75; recv_idle_pct = 11;
      write_csr(CSR_CLIP_MODE, 32'(MODE_PLANE));
      write_csr(CSR_PLANE_ADD, 32'hFFFF_8000);
      write_csr(CSR_X_SCALE, 32'h0001_0000);
      write_csr(CSR_Y_SCALE, 32'hFFFF_FFFF);
      write_csr(CSR_Y_ORIGIN, 32'h8000_0000);
      random_phase(100);
      send_idle_pct = 0;
      recv_hold = 1;
      fork
         begin
            repeat (200) @(posedge clock);
            recv_hold = 0;
         end
         random_phase(60);
      join
      send_idle_pct = 75;
      random_phase(200);
      wait_idle();
      write_csr(CSR_PLANE_ADD, 32'h0000_7FFF);
      write_csr(CSR_Y_SCALE, 32'h0001_0000);
      write_csr(CSR_Y_ORIGIN, 32'h0);
      write_csr(CSR_X_ORIGIN, 32'h7FFF_FFFF);
      random_phase(100);
      wait_idle();

      // Phase 3: no idling; constant mode then unused mode
      send_idle_pct = 0; recv_idle_pct = 0;
      write_csr(CSR_X_ORIGIN, 32'h0);
      write_csr(CSR_CLIP_MODE, 32'(MODE_CONST));
      write_csr(CSR_CLIP_CONSTANT, 32'h0000_8000);
      random_phase(200);
      wait_idle();
      write_csr(CSR_CLIP_CONSTANT, 32'h0000_7FFF);
      random_phase(200);
      wait_idle();
      write_csr(CSR_CLIP_MODE, 32'(MODE_KEEP));
      random_phase(200);
      wait_idle();

      if (error_count == 0 && expected_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
